// ===== rtl/iqm_pkg.sv =====
// shared types, codes and defaults of the io latency queue monitor
`default_nettype none
package iqm_pkg;

   // default sizes
   localparam int TAG_COUNT_DEF    = 64;
   localparam int DEVICE_COUNT_DEF = 8;
   localparam int HIST_BINS_DEF    = 40;

   // fixed field widths
   localparam int TIME_W  = 64;
   localparam int LEN_W   = 32;
   localparam int CNT_W   = 64;
   localparam int DEPTH_W = 7;
   localparam int STAT_W  = 4;
   localparam int BIN_W   = 6;
   localparam int TAGF_W  = 6;
   localparam int DEVF_W  = 3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_ISSUED     = 4'd0;
   localparam logic [STAT_W-1:0] ST_UNTRACKED  = 4'd1;
   localparam logic [STAT_W-1:0] ST_DUPLICATE  = 4'd2;
   localparam logic [STAT_W-1:0] ST_MISS       = 4'd3;
   localparam logic [STAT_W-1:0] ST_IGNORED    = 4'd4;
   localparam logic [STAT_W-1:0] ST_PARTIAL    = 4'd5;
   localparam logic [STAT_W-1:0] ST_DONE       = 4'd6;
   localparam logic [STAT_W-1:0] ST_DONE_UNTRK = 4'd7;
   localparam logic [STAT_W-1:0] ST_DEV_MISS   = 4'd8;

   // event kinds
   localparam logic KIND_ISSUE = 1'b0;

   // controller states
   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_UPD   = 5'b01000,
      S_WB    = 5'b10000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic exec;
      logic upd;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/io_latency_queue_monitor_core.sv =====
// top level of the io latency queue monitor
// Usage:
//   issue and completion items enter on the req_ channel (valid/stall) and
//   each item returns exactly one result item on the rsp_ channel, carrying
//   a status code and the updated counters of the reported device.
//   csr_wr_en/csr_wr_data write the startup boundary; write it only while
//   no item is in flight. A zero boundary leaves every request untracked.
// Timing:
//   an item goes through execute (table read-modify-write), update (area
//   product, latency bin, histogram read) and write-back, where its result
//   is registered; a new item is taken only after the last one has left
//   write-back, and write-back waits while rsp_stall holds a result.
// Reset:
//   the request table valid bits and the device counters clear at once; the
//   histogram memory is then swept to zero, every one of its
//   DEVICE_COUNT*HIST_BINS entries (320 by default), with req_stall high.
// Stall:
//   while rsp_stall holds a result, the held item stays and one further item
//   runs up to write-back and waits there.
`default_nettype none
module io_latency_queue_monitor_core #(
   parameter int TAG_COUNT    = iqm_pkg::TAG_COUNT_DEF,
   parameter int DEVICE_COUNT = iqm_pkg::DEVICE_COUNT_DEF,
   parameter int HIST_BINS    = iqm_pkg::HIST_BINS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire  [iqm_pkg::TIME_W-1:0]          csr_wr_data,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_kind,
   input  wire  [iqm_pkg::TAGF_W-1:0]          req_tag,
   input  wire  [iqm_pkg::DEVF_W-1:0]          req_device,
   input  wire  [iqm_pkg::TIME_W-1:0]          req_now_ns,
   input  wire  [iqm_pkg::LEN_W-1:0]           req_length,
   input  wire  [iqm_pkg::LEN_W-1:0]           req_done_bytes,
   input  wire                                 req_failed,
   input  wire  [iqm_pkg::TIME_W-1:0]          req_alloc_time,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [iqm_pkg::STAT_W-1:0]          rsp_status,
   output logic                                rsp_error_counted,
   output logic [iqm_pkg::DEVF_W-1:0]          rsp_dev_index,
   output logic [iqm_pkg::TIME_W-1:0]          rsp_latency_ns,
   output logic [iqm_pkg::BIN_W-1:0]           rsp_latency_bin,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_bin_count,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_count,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_latency_sum,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_bytes,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_queue_area,
   output logic [iqm_pkg::DEPTH_W-1:0]         rsp_dev_inflight
);

   iqm_pkg::cmd_type cmd;
   iqm_pkg::sts_type sts;

   // sequencer
   iqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // tables, counters and result register
   iqm_datapath #(
      .TAG_COUNT    (TAG_COUNT),
      .DEVICE_COUNT (DEVICE_COUNT),
      .HIST_BINS    (HIST_BINS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_kind            (req_kind),
      .req_tag             (req_tag),
      .req_device          (req_device),
      .req_now_ns          (req_now_ns),
      .req_length          (req_length),
      .req_done_bytes      (req_done_bytes),
      .req_failed          (req_failed),
      .req_alloc_time      (req_alloc_time),
      .rsp_status          (rsp_status),
      .rsp_error_counted   (rsp_error_counted),
      .rsp_dev_index       (rsp_dev_index),
      .rsp_latency_ns      (rsp_latency_ns),
      .rsp_latency_bin     (rsp_latency_bin),
      .rsp_bin_count       (rsp_bin_count),
      .rsp_dev_count       (rsp_dev_count),
      .rsp_dev_latency_sum (rsp_dev_latency_sum),
      .rsp_dev_bytes       (rsp_dev_bytes),
      .rsp_dev_queue_area  (rsp_dev_queue_area),
      .rsp_dev_inflight    (rsp_dev_inflight)
   );

endmodule
`default_nettype wire

// ===== rtl/iqm_ctrl.sv =====
// controller state machine of the io latency queue monitor
`default_nettype none
module iqm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output iqm_pkg::cmd_type    cmd,
   input  iqm_pkg::sts_type    sts
);

   iqm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != iqm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         iqm_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = iqm_pkg::S_IDLE;
         end
         iqm_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = iqm_pkg::S_EXEC;
            end
         end
         iqm_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = iqm_pkg::S_UPD;
         end
         iqm_pkg::S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = iqm_pkg::S_WB;
         end
         iqm_pkg::S_WB: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = iqm_pkg::S_IDLE;
            end
         end
         default: state_in = iqm_pkg::S_CLEAR;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iqm_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/iqm_datapath.sv =====
// request table, device counters and histogram memory of the monitor
`default_nettype none
module iqm_datapath #(
   parameter int TAG_COUNT    = iqm_pkg::TAG_COUNT_DEF,
   parameter int DEVICE_COUNT = iqm_pkg::DEVICE_COUNT_DEF,
   parameter int HIST_BINS    = iqm_pkg::HIST_BINS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  iqm_pkg::cmd_type                    cmd,
   output iqm_pkg::sts_type                    sts,
   input  wire                                 csr_wr_en,
   input  wire  [iqm_pkg::TIME_W-1:0]          csr_wr_data,
   input  wire                                 req_kind,
   input  wire  [iqm_pkg::TAGF_W-1:0]          req_tag,
   input  wire  [iqm_pkg::DEVF_W-1:0]          req_device,
   input  wire  [iqm_pkg::TIME_W-1:0]          req_now_ns,
   input  wire  [iqm_pkg::LEN_W-1:0]           req_length,
   input  wire  [iqm_pkg::LEN_W-1:0]           req_done_bytes,
   input  wire                                 req_failed,
   input  wire  [iqm_pkg::TIME_W-1:0]          req_alloc_time,
   output logic [iqm_pkg::STAT_W-1:0]          rsp_status,
   output logic                                rsp_error_counted,
   output logic [iqm_pkg::DEVF_W-1:0]          rsp_dev_index,
   output logic [iqm_pkg::TIME_W-1:0]          rsp_latency_ns,
   output logic [iqm_pkg::BIN_W-1:0]           rsp_latency_bin,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_bin_count,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_count,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_latency_sum,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_bytes,
   output logic [iqm_pkg::CNT_W-1:0]           rsp_dev_queue_area,
   output logic [iqm_pkg::DEPTH_W-1:0]         rsp_dev_inflight
);

   localparam int TAG_W      = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
   localparam int DEV_W      = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
   localparam int HIST_DEPTH = DEVICE_COUNT * HIST_BINS;
   localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int TAG_SPAN   = 1 << iqm_pkg::TAGF_W;
   localparam int TW         = iqm_pkg::TIME_W;
   localparam int CW         = iqm_pkg::CNT_W;
   localparam int LW         = iqm_pkg::LEN_W;
   localparam int DW         = iqm_pkg::DEPTH_W;

   // one request table word
   typedef struct packed {
      logic [TW-1:0]                 issue_time;
      logic [LW-1:0]                 total_bytes;
      logic [CW-1:0]                 good_bytes;
      logic [iqm_pkg::DEVF_W-1:0]    device;
      logic                          tracked;
   } entry_type;

   // tag reduction table
   logic [TAG_W-1:0] tag_map [TAG_SPAN];
   for (genvar gi = 0; gi < TAG_SPAN; gi++) begin : g_tag
      assign tag_map[gi] = TAG_W'(gi % TAG_COUNT);
   end

   // configuration
   logic [TW-1:0] boundary_ff;
   always_ff @(posedge clock) begin
      if (reset) boundary_ff <= '0;
      else if (csr_wr_en) boundary_ff <= csr_wr_data;
   end

   // captured item
   logic                         kind_ff;
   logic [TAG_W-1:0]             tag_ff;
   logic [iqm_pkg::DEVF_W-1:0]   dev_in_ff;
   logic [TW-1:0]                now_ff, alloc_ff;
   logic [LW-1:0]                len_ff, done_ff;
   logic                         failed_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         tag_ff    <= tag_map[req_tag];
         dev_in_ff <= req_device;
         now_ff    <= req_now_ns;
         len_ff    <= req_length;
         done_ff   <= req_done_bytes;
         failed_ff <= req_failed;
         alloc_ff  <= req_alloc_time;
      end
   end

   // request table memory with registered read at capture
   entry_type ent_mem [TAG_COUNT];
   entry_type ent_rd_ff;
   entry_type ent_wr;
   logic      ent_we;
   always_ff @(posedge clock) begin
      if (cmd.capture) ent_rd_ff <= ent_mem[tag_map[req_tag]];
      if (ent_we) ent_mem[tag_ff] <= ent_wr;
   end

   // valid bits of the table
   logic entry_valid_ff [TAG_COUNT];
   logic valid_we, valid_val;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAG_COUNT; i++) entry_valid_ff[i] <= 1'b0;
      end else if (valid_we) begin
         entry_valid_ff[tag_ff] <= valid_val;
      end
   end

   // device counters
   logic          dev_present_ff [DEVICE_COUNT];
   logic [CW-1:0] dev_cnt_ff     [DEVICE_COUNT];
   logic [CW-1:0] dev_lat_ff     [DEVICE_COUNT];
   logic [CW-1:0] dev_byt_ff     [DEVICE_COUNT];
   logic [CW-1:0] dev_area_ff    [DEVICE_COUNT];
   logic [TW-1:0] dev_last_ff    [DEVICE_COUNT];
   logic [DW-1:0] dev_depth_ff   [DEVICE_COUNT];

   // execute stage results
   logic [iqm_pkg::STAT_W-1:0] status_ff, status_in;
   logic                       err_ff, err_in;
   logic [iqm_pkg::DEVF_W-1:0] d_ff, d_in;
   logic [TW-1:0]              lat_ff, lat_in;
   logic [TW-1:0]              delta_ff, delta_in;
   logic [CW-1:0]              acc_ff, acc_in;

   logic                       d_ok;
   logic [DEV_W-1:0]           d_idx, dx_idx;
   logic                       ent_valid;
   logic [CW-1:0]              good_new;
   logic [TW-1:0]              last_c;
   logic [DW-1:0]              depth_c;

   assign ent_valid = entry_valid_ff[tag_ff];

   // classify the item and update the table
   always_comb begin
      status_in = iqm_pkg::ST_IGNORED;
      err_in    = 1'b0;
      d_in      = '0;
      lat_in    = '0;
      delta_in  = '0;
      acc_in    = '0;
      ent_we    = 1'b0;
      ent_wr    = ent_rd_ff;
      valid_we  = 1'b0;
      valid_val = 1'b0;
      good_new  = ent_rd_ff.good_bytes;
      if (kind_ff == iqm_pkg::KIND_ISSUE) begin
         d_in = dev_in_ff;
         if (ent_valid) begin
            status_in = iqm_pkg::ST_DUPLICATE;
         end else begin
            ent_we             = cmd.exec;
            valid_we           = cmd.exec;
            valid_val          = 1'b1;
            ent_wr.issue_time  = now_ff;
            ent_wr.total_bytes = len_ff;
            ent_wr.good_bytes  = '0;
            ent_wr.device      = dev_in_ff;
            ent_wr.tracked     = (boundary_ff != '0);
            if (boundary_ff == '0) status_in = iqm_pkg::ST_UNTRACKED;
            else if (!d_ok) status_in = iqm_pkg::ST_DEV_MISS;
            else status_in = iqm_pkg::ST_ISSUED;
         end
      end else if (!ent_valid) begin
         if (boundary_ff != '0 && alloc_ff != '0 && alloc_ff >= boundary_ff)
            status_in = iqm_pkg::ST_MISS;
         else
            status_in = iqm_pkg::ST_IGNORED;
      end else begin
         d_in = ent_rd_ff.device;
         if (ent_rd_ff.tracked && failed_ff) err_in = 1'b1;
         else if (ent_rd_ff.tracked) good_new = ent_rd_ff.good_bytes + CW'(done_ff);
         ent_wr.good_bytes = good_new;
         ent_we            = cmd.exec;
         if (done_ff < len_ff) begin
            status_in = iqm_pkg::ST_PARTIAL;
         end else begin
            valid_we = cmd.exec;
            if (!ent_rd_ff.tracked) status_in = iqm_pkg::ST_DONE_UNTRK;
            else if (!d_ok || !dev_present_ff[dx_idx]) status_in = iqm_pkg::ST_DEV_MISS;
            else status_in = iqm_pkg::ST_DONE;
         end
      end
      if (status_in == iqm_pkg::ST_DONE) begin
         lat_in = (now_ff > ent_rd_ff.issue_time) ? now_ff - ent_rd_ff.issue_time : '0;
         acc_in = (good_new > CW'(ent_rd_ff.total_bytes)) ?
                  CW'(ent_rd_ff.total_bytes) : good_new;
      end
      if (last_c != '0 && now_ff > last_c && depth_c != '0) delta_in = now_ff - last_c;
   end

   // device of the current item for the execute stage
   logic [iqm_pkg::DEVF_W-1:0] d_sel;
   assign d_sel   = (kind_ff == iqm_pkg::KIND_ISSUE) ? dev_in_ff : ent_rd_ff.device;
   assign d_ok    = (32'(d_sel) < 32'(DEVICE_COUNT));
   assign dx_idx  = DEV_W'(d_sel);
   assign last_c  = dev_last_ff[dx_idx];
   assign depth_c = dev_depth_ff[dx_idx];

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         err_ff    <= err_in;
         d_ff      <= d_in;
         lat_ff    <= lat_in;
         delta_ff  <= delta_in;
         acc_ff    <= acc_in;
      end
   end

   // update stage: area product, latency bin, histogram read
   logic [BIN_W_L-1:0] bin_raw;
   localparam int BIN_W_L = iqm_pkg::BIN_W;
   logic [BIN_W_L-1:0] bin_c, bin_ff;
   logic [CW-1:0]      prod_ff;
   logic [HADDR_W-1:0] hist_rd_addr, hist_wr_addr, clr_ff;
   logic [CW-1:0]      hist_mem [HIST_DEPTH];
   logic [CW-1:0]      hist_rd_ff;
   logic               hist_we;
   logic [CW-1:0]      hist_wr_data;
   logic [HADDR_W-1:0] hist_wr_sel;

   assign d_idx = DEV_W'(d_ff);

   always_comb begin
      bin_raw = '0;
      for (int i = 1; i < TW; i++) begin
         if (lat_ff[i]) bin_raw = BIN_W_L'(i);
      end
      bin_c = (32'(bin_raw) >= 32'(HIST_BINS)) ? BIN_W_L'(HIST_BINS - 1) : bin_raw;
   end

   assign hist_rd_addr = HADDR_W'(32'(d_idx) * HIST_BINS + 32'(bin_c));
   assign hist_wr_addr = HADDR_W'(32'(d_idx) * HIST_BINS + 32'(bin_ff));

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         bin_ff     <= bin_c;
         prod_ff    <= delta_ff * CW'(dev_depth_ff[d_idx]);
         hist_rd_ff <= hist_mem[hist_rd_addr];
      end
   end

   // clearing pass over the histogram after reset
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end
   assign sts.clear_done = (32'(clr_ff) == HIST_DEPTH - 1);

   // histogram write port
   logic upd_done, upd_issue;
   assign upd_done  = cmd.load_out && (status_ff == iqm_pkg::ST_DONE);
   assign upd_issue = cmd.load_out && (status_ff == iqm_pkg::ST_ISSUED);
   assign hist_we      = cmd.clear_step || upd_done;
   assign hist_wr_sel  = cmd.clear_step ? clr_ff : hist_wr_addr;
   assign hist_wr_data = cmd.clear_step ? '0 : hist_rd_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_wr_sel] <= hist_wr_data;
   end

   // new device counter values
   logic [CW-1:0] cnt_n, lat_n, byt_n, area_n;
   logic [DW-1:0] depth_n;
   logic          upd_any, rep_ok;
   assign upd_any = upd_done || upd_issue;
   always_comb begin
      cnt_n   = dev_cnt_ff[d_idx];
      lat_n   = dev_lat_ff[d_idx];
      byt_n   = dev_byt_ff[d_idx];
      area_n  = dev_area_ff[d_idx];
      depth_n = dev_depth_ff[d_idx];
      if (upd_any) area_n = dev_area_ff[d_idx] + prod_ff;
      if (upd_issue) depth_n = dev_depth_ff[d_idx] + 1'b1;
      if (upd_done) begin
         if (dev_depth_ff[d_idx] != '0) depth_n = dev_depth_ff[d_idx] - 1'b1;
         cnt_n = dev_cnt_ff[d_idx] + 1'b1;
         lat_n = dev_lat_ff[d_idx] + lat_ff;
         byt_n = dev_byt_ff[d_idx] + acc_ff;
      end
   end
   assign rep_ok = (32'(d_ff) < 32'(DEVICE_COUNT)) && (dev_present_ff[d_idx] || upd_issue);

   // device counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEVICE_COUNT; i++) begin
            dev_present_ff[i] <= 1'b0;
            dev_cnt_ff[i]     <= '0;
            dev_lat_ff[i]     <= '0;
            dev_byt_ff[i]     <= '0;
            dev_area_ff[i]    <= '0;
            dev_last_ff[i]    <= '0;
            dev_depth_ff[i]   <= '0;
         end
      end else if (upd_any) begin
         dev_present_ff[d_idx] <= 1'b1;
         dev_cnt_ff[d_idx]     <= cnt_n;
         dev_lat_ff[d_idx]     <= lat_n;
         dev_byt_ff[d_idx]     <= byt_n;
         dev_area_ff[d_idx]    <= area_n;
         dev_last_ff[d_idx]    <= now_ff;
         dev_depth_ff[d_idx]   <= depth_n;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status          <= status_ff;
         rsp_error_counted   <= err_ff;
         rsp_dev_index       <= d_ff;
         rsp_latency_ns      <= lat_ff;
         rsp_latency_bin     <= upd_done ? bin_ff : '0;
         rsp_bin_count       <= upd_done ? hist_rd_ff + 1'b1 : '0;
         rsp_dev_count       <= rep_ok ? cnt_n : '0;
         rsp_dev_latency_sum <= rep_ok ? lat_n : '0;
         rsp_dev_bytes       <= rep_ok ? byt_n : '0;
         rsp_dev_queue_area  <= rep_ok ? area_n : '0;
         rsp_dev_inflight    <= rep_ok ? depth_n : '0;
      end
   end

endmodule
`default_nettype wire
